FILE: design/plia_pkg.sv
// ----------------------------------------------------------------------------
// plia_pkg
// shared types and constants of the posting list intersect accumulate block
// ----------------------------------------------------------------------------
package plia_pkg;

    // input command codes
    typedef enum logic [1:0] {
        CMD_QUERY = 2'd0,
        CMD_CHUNK = 2'd1,
        CMD_LOAD  = 2'd2,
        CMD_PROBE = 2'd3
    } t_cmd;

    // result status codes
    localparam logic [1:0] STAT_OK         = 2'd0;
    localparam logic [1:0] STAT_TABLE_FULL = 2'd1;
    localparam logic [1:0] STAT_FOUND_FULL = 2'd2;

    // configuration register indexes
    localparam logic REG_TERM_COUNT = 1'b0;
    localparam logic REG_MAX_FOUND  = 1'b1;

    localparam logic [4:0]  COUNT_LIMIT = 5'd31;
    localparam logic [19:0] SUM_LIMIT   = 20'hFFFFF;
    localparam logic [23:0] SCORE_LIMIT = 24'hFFFFFF;
    localparam logic [12:0] FOUND_LIMIT = 13'd4096;
    localparam int          DIV_W       = 28;

    // one queued input item
    typedef struct packed {
        t_cmd        cmd;
        logic [31:0] page;
        logic [15:0] weight;
    } t_item;

    // one table entry
    typedef struct packed {
        logic [31:0] key;
        logic [4:0]  count;
        logic [19:0] sum;
    } t_entry;

    // one result transaction, hit in the lowest bit
    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] found_index;
        logic [23:0] mean_score;
        logic [31:0] found_page;
        logic        hit;
    } t_result;

endpackage

FILE: design/plia_front.sv
// ----------------------------------------------------------------------------
// plia_front
// accepts input transactions, decodes the command and queues them (2 deep)
// ----------------------------------------------------------------------------
module plia_front
    import plia_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_page,
    input  logic [15:0] i_weight,
    output logic        o_q_valid,
    output t_item       o_q_item,
    input  logic        i_q_pop
);

    t_item      r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt;
    logic       push;
    t_item      item;

    // decode the command field
    always_comb begin
        case (i_cmd)
            2'd0:    item.cmd = CMD_QUERY;
            2'd1:    item.cmd = CMD_CHUNK;
            2'd2:    item.cmd = CMD_LOAD;
            default: item.cmd = CMD_PROBE;
        endcase
        item.page   = i_page;
        item.weight = i_weight;
    end

    assign o_ready   = (r_cnt != 2'd2);
    assign push      = i_valid && o_ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_q[r_rd_ptr];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= item;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (push) r_wr_ptr <= ~r_wr_ptr;
            if (i_q_pop) r_rd_ptr <= ~r_rd_ptr;
            r_cnt <= r_cnt + 2'(push) - 2'(i_q_pop);
        end
    end

endmodule

FILE: design/plia_div.sv
// ----------------------------------------------------------------------------
// plia_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module plia_div
    import plia_pkg::*;
#(
    parameter int VW = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_dividend,
    input  logic [VW-1:0]    i_divisor,
    output logic             o_done,
    output logic [DIV_W-1:0] o_quotient
);

    localparam int NW = $clog2(DIV_W + 1);

    logic [VW-1:0]    r_rem;
    logic [DIV_W-1:0] r_quo;
    logic [VW-1:0]    r_dsr;
    logic [NW-1:0]    r_n;
    logic             r_busy;
    logic             r_done;
    logic [VW:0]      rem_sh;
    logic             ge;

    assign rem_sh     = {r_rem, r_quo[DIV_W-1]};
    assign ge         = (rem_sh >= {1'b0, r_dsr});
    assign o_done     = r_done;
    assign o_quotient = r_quo;

    // datapath, the remainder always stays below the divisor
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? VW'(rem_sh - {1'b0, r_dsr}) : rem_sh[VW-1:0];
            r_quo <= {r_quo[DIV_W-2:0], ge};
        end
    end

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_n    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_n    <= NW'(DIV_W - 1);
            end else if (r_busy) begin
                r_n <= r_n - 1'b1;
                if (r_n == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

FILE: design/plia_back.sv
// ----------------------------------------------------------------------------
// plia_back
// executes queued items: table scan, update, emit and output register
// ----------------------------------------------------------------------------
module plia_back
    import plia_pkg::*;
#(
    parameter int TABLE_ENTRIES = 256,
    parameter int TW            = 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [TW-1:0] i_terms,
    input  logic [12:0]   i_max_found,
    input  logic          i_q_valid,
    input  t_item         i_q_item,
    output logic          o_q_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output t_result       o_result
);

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int KW = (TW > 6) ? TW : 6;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RD   = 5'b00010,
        S_CMP  = 5'b00100,
        S_DIV  = 5'b01000,
        S_PUT  = 5'b10000
    } t_state;

    t_entry  mem [TABLE_ENTRIES];
    t_entry  r_rd;
    t_state  r_state, n_state;
    t_item   r_cur, n_cur;
    t_result r_res, n_res;
    t_result r_out, n_out;
    logic    r_out_valid, n_out_valid;
    logic [IW-1:0] r_idx, n_idx;
    logic [IW:0]   r_fill, n_fill;
    logic [12:0]   r_found, n_found;
    logic          mem_we;
    logic [IW-1:0] mem_wa;
    t_entry        mem_wd;
    logic          div_start;
    logic [DIV_W-1:0] div_q;
    logic          div_done;
    logic [20:0]   sum_raw;
    logic [19:0]   sum_sat;
    logic [5:0]    cnt_inc;
    logic          found_full;

    assign sum_raw    = {1'b0, r_rd.sum} + {5'd0, r_cur.weight};
    assign sum_sat    = sum_raw[20] ? SUM_LIMIT : sum_raw[19:0];
    assign cnt_inc    = {1'b0, r_rd.count} + 6'd1;
    assign found_full = (r_found >= i_max_found);
    assign o_valid    = r_out_valid;
    assign o_result   = r_out;

    plia_div #(.VW(TW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({sum_sat, 8'd0}),
        .i_divisor  (i_terms),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_cur       = r_cur;
        n_res       = r_res;
        n_idx       = r_idx;
        n_fill      = r_fill;
        n_found     = r_found;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_ready;
        o_q_pop     = 1'b0;
        mem_we      = 1'b0;
        mem_wa      = r_idx;
        mem_wd      = '{key: r_cur.page, count: 5'd1, sum: {4'd0, r_cur.weight}};
        div_start   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_cur   = i_q_item;
                    n_res   = '0;
                    n_idx   = '0;
                    n_state = S_PUT;
                    case (i_q_item.cmd)
                        CMD_QUERY: begin
                            n_fill  = '0;
                            n_found = '0;
                        end
                        CMD_CHUNK: n_fill = '0;
                        CMD_LOAD: begin
                            if (i_terms == TW'(1)) begin
                                if (found_full) begin
                                    n_res.status = STAT_FOUND_FULL;
                                end else begin
                                    n_res.hit         = 1'b1;
                                    n_res.found_page  = i_q_item.page;
                                    n_res.mean_score  = {i_q_item.weight, 8'd0};
                                    n_res.found_index = r_found[11:0];
                                    n_found           = r_found + 13'd1;
                                end
                            end else if (r_fill != '0) begin
                                n_state = S_RD;
                            end else begin
                                // empty table: first entry
                                mem_we  = 1'b1;
                                mem_wa  = '0;
                                mem_wd  = '{key: i_q_item.page, count: 5'd1,
                                            sum: {4'd0, i_q_item.weight}};
                                n_fill  = r_fill + 1'b1;
                            end
                        end
                        default: begin
                            if (r_fill != '0) n_state = S_RD;
                        end
                    endcase
                end
            end
            S_RD: n_state = S_CMP;
            S_CMP: begin
                n_state = S_PUT;
                if (r_rd.key == r_cur.page) begin
                    mem_we = 1'b1;
                    if (r_cur.cmd == CMD_PROBE) begin
                        mem_wd.sum   = sum_sat;
                        mem_wd.count = r_rd.count;
                        if (r_rd.count < COUNT_LIMIT) begin
                            mem_wd.count = cnt_inc[4:0];
                            if (KW'(cnt_inc) == KW'(i_terms)) begin
                                if (found_full) begin
                                    n_res.status = STAT_FOUND_FULL;
                                end else begin
                                    div_start = 1'b1;
                                    n_state   = S_DIV;
                                end
                            end
                        end
                    end
                end else if (({1'b0, r_idx} + 1'b1) < r_fill) begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_RD;
                end else if (r_cur.cmd == CMD_LOAD) begin
                    // miss: append or drop
                    if (r_fill >= (IW + 1)'(TABLE_ENTRIES)) begin
                        n_res.status = STAT_TABLE_FULL;
                    end else begin
                        mem_we = 1'b1;
                        mem_wa = r_fill[IW-1:0];
                        n_fill = r_fill + 1'b1;
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_res.hit         = 1'b1;
                    n_res.found_page  = r_cur.page;
                    n_res.mean_score  = (|div_q[DIV_W-1:24]) ? SCORE_LIMIT : div_q[23:0];
                    n_res.found_index = r_found[11:0];
                    n_found           = r_found + 13'd1;
                    n_state           = S_PUT;
                end
            end
            S_PUT: begin
                if (!r_out_valid || i_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // table memory
    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        r_rd <= mem[r_idx];
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        r_res <= n_res;
        r_idx <= n_idx;
        r_out <= n_out;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_found     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

FILE: design/posting_list_intersect_accumulate.sv
// ----------------------------------------------------------------------------
// posting_list_intersect_accumulate
// intersects posting lists and reports fully matched pages with mean weight
// ----------------------------------------------------------------------------
// input stream: s_axis_tuser carries the command (new query, new chunk, load,
// probe), s_axis_tdata the page id and weight. every input transaction gives
// exactly one output transaction on the m_axis side, in order.
// configuration: i_cfg_we with i_cfg_idx selects term count (0) or max found
// (1); write only while no item is in flight.
// queries, chunks and single-term loads go from the queue straight to the
// output register. loads and probes scan the table linearly through the
// single memory read port, reading and then comparing each entry in use; a
// probe that completes a page then waits for the bit-serial divider.
// a 2-deep input queue keeps taking items while the back end works, and the
// output register holds a result while the next item is already processed.
// when the receiver stalls the result holds; once the queue is full,
// s_axis_tready drops.
// reset clears the table fill count, the found count and all handshakes; the
// table memory itself needs no clearing pass.
// ----------------------------------------------------------------------------
module posting_list_intersect_accumulate
    import plia_pkg::*;
#(
    parameter int TABLE_ENTRIES = 256,
    parameter int MAX_TERMS     = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // page_id, weight
    input  logic [1:0]  s_axis_tuser,  // cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,  // hit, found_page, mean_score, found_index, status
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [12:0] i_cfg_data
);

    localparam int TW = $clog2(MAX_TERMS + 1);

    logic [4:0]    r_term_count;
    logic [12:0]   r_max_found;
    logic [TW-1:0] eff_terms;
    logic [12:0]   eff_max;
    logic          q_valid;
    t_item         q_item;
    logic          q_pop;
    t_result       result;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term_count <= 5'd1;
            r_max_found  <= 13'd16;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_TERM_COUNT: r_term_count <= i_cfg_data[4:0];
                REG_MAX_FOUND:  r_max_found  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // effective limits
    always_comb begin
        if (r_term_count == 5'd0) eff_terms = TW'(1);
        else if (32'(r_term_count) > 32'(MAX_TERMS)) eff_terms = TW'(MAX_TERMS);
        else eff_terms = TW'(r_term_count);
        eff_max = (r_max_found > FOUND_LIMIT) ? FOUND_LIMIT : r_max_found;
    end

    plia_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_cmd     (s_axis_tuser),
        .i_page    (s_axis_tdata[31:0]),
        .i_weight  (s_axis_tdata[47:32]),
        .o_q_valid (q_valid),
        .o_q_item  (q_item),
        .i_q_pop   (q_pop)
    );

    plia_back #(.TABLE_ENTRIES(TABLE_ENTRIES), .TW(TW)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_terms     (eff_terms),
        .i_max_found (eff_max),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_q_pop     (q_pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_result    (result)
    );

    assign m_axis_tdata = {1'b0, result};

endmodule

FILE: bench/posting_list_intersect_accumulate_tb.sv
// ----------------------------------------------------------------------------
// posting_list_intersect_accumulate_tb
// drives query, chunk, load and probe commands with random gaps and output
// stalls, predicts every result from a local copy of the table and counters,
// and compares each output transaction field by field in order
// ----------------------------------------------------------------------------
module posting_list_intersect_accumulate_tb;
    import plia_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRIES  = 256;
    localparam int TERM_MAX = 16;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;   // page_id, weight
    logic [1:0]  s_axis_tuser;   // cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;   // hit, found_page, mean_score, found_index, status
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [12:0] i_cfg_data;

    posting_list_intersect_accumulate uut (.*);

    // predictor state
    logic [4:0]  terms_reg;
    logic [12:0] max_found_reg;
    logic [31:0] tbl_key   [ENTRIES];
    logic [4:0]  tbl_count [ENTRIES];
    logic [19:0] tbl_sum   [ENTRIES];
    int unsigned tbl_fill;
    int unsigned found_total;

    t_result     expected_results[$];
    int          mismatch_count;
    int          result_count;
    int          hit_count;
    int          item_count;
    int          hold_cycles;   // receiver hold-off request
    bit          random_stall;

    // recent page ids so probes tend to match
    logic [31:0] page_pool[$];

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("Mismatches found");
        $finish;
    end

    function automatic int unsigned clamp_terms();
        if (terms_reg == 0) return 1;
        if (terms_reg > TERM_MAX) return TERM_MAX;
        return terms_reg;
    endfunction

    // emit a completed page or flag a full found list
    function automatic t_result emit_page(logic [31:0] page, logic [19:0] sum,
                                          int unsigned terms);
        t_result     r;
        int unsigned lim;
        logic [63:0] score;
        r = '0;
        lim = (max_found_reg > FOUND_LIMIT) ? FOUND_LIMIT : max_found_reg;
        if (found_total >= lim) begin
            r.status = STAT_FOUND_FULL;
            return r;
        end
        score = ({44'd0, sum} << 8) / terms;
        if (score > SCORE_LIMIT) score = SCORE_LIMIT;
        r.hit = 1'b1;
        r.found_page = page;
        r.mean_score = score[23:0];
        r.found_index = found_total[11:0];
        found_total++;
        return r;
    endfunction

    function automatic t_result predict_item(t_cmd cmd, logic [31:0] page,
                                             logic [15:0] weight);
        t_result     r;
        int unsigned terms;
        logic [20:0] acc;
        r = '0;
        terms = clamp_terms();
        case (cmd)
            CMD_QUERY: begin
                tbl_fill = 0;
                found_total = 0;
            end
            CMD_CHUNK: begin
                tbl_fill = 0;
            end
            CMD_LOAD: begin
                if (terms == 1) return emit_page(page, {4'd0, weight}, 1);
                for (int i = 0; i < tbl_fill; i++)
                    if (tbl_key[i] == page) begin
                        tbl_count[i] = 1;
                        tbl_sum[i] = {4'd0, weight};
                        return r;
                    end
                if (tbl_fill >= ENTRIES) begin
                    r.status = STAT_TABLE_FULL;
                    return r;
                end
                tbl_key[tbl_fill] = page;
                tbl_count[tbl_fill] = 1;
                tbl_sum[tbl_fill] = {4'd0, weight};
                tbl_fill++;
            end
            default: begin
                for (int i = 0; i < tbl_fill; i++)
                    if (tbl_key[i] == page) begin
                        acc = tbl_sum[i] + weight;
                        if (acc > SUM_LIMIT) acc = SUM_LIMIT;
                        tbl_sum[i] = acc[19:0];
                        if (tbl_count[i] < COUNT_LIMIT) begin
                            tbl_count[i]++;
                            if (tbl_count[i] == terms) r = emit_page(page, acc[19:0], terms);
                        end
                        break;
                    end
            end
        endcase
        return r;
    endfunction

    // send one item, predicting its result at acceptance
    task automatic send_item(t_cmd cmd, logic [31:0] page, logic [15:0] weight,
                             int max_gap = 10);
        repeat ($urandom_range(0, max_gap)) @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser = cmd;
        s_axis_tdata = {weight, page};
        do @(posedge i_clk); while (!s_axis_tready);
        expected_results.insert(expected_results.size(), predict_item(cmd, page, weight));
        item_count++;
        if (cmd == CMD_LOAD) begin
            page_pool.insert(page_pool.size(), page);
            if (page_pool.size() > 40) void'(page_pool.pop_front());
        end
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [12:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_TERM_COUNT) terms_reg = value[4:0];
        else max_found_reg = value;
    endtask

    // receiver stalls
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                m_axis_tready <= 1'b0;
                repeat (hold_cycles) @(negedge i_clk);
                hold_cycles = 0;
            end
            if (random_stall && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= (random_stall && $urandom_range(0, 2) == 0) ? 1'b0 : 1'b1;
            end
        end
    end

    // output checker
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[70:0];
            result_count++;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                if (got.hit != want.hit || got.found_page != want.found_page ||
                    got.mean_score != want.mean_score ||
                    got.found_index != want.found_index || got.status != want.status) begin
                    $display("%0t: expected hit=%0d page=%h score=%h idx=%0d st=%0d",
                             $time, want.hit, want.found_page, want.mean_score,
                             want.found_index, want.status);
                    $display("%0t: actual   hit=%0d page=%h score=%h idx=%0d st=%0d",
                             $time, got.hit, got.found_page, got.mean_score,
                             got.found_index, got.status);
                    mismatch_count++;
                end
                if (got.hit) hit_count++;
            end
        end
    end

    // directed: field extremes, every command, one-term paths
    task automatic test_directed();
        send_item(CMD_QUERY, 32'hFFFF_FFFF, 16'hFFFF);
        send_item(CMD_LOAD, 32'h0, 16'h0);
        send_item(CMD_LOAD, 32'hFFFF_FFFF, 16'hFFFF);
        send_item(CMD_PROBE, 32'hFFFF_FFFF, 16'hFFFF);    // one term: no emit
        wait_drained();
        write_reg(REG_TERM_COUNT, 13'd2);
        send_item(CMD_CHUNK, 32'h0, 16'h0);
        send_item(CMD_LOAD, 32'hA5A5_5A5A, 16'hFFFF);
        send_item(CMD_LOAD, 32'hA5A5_5A5A, 16'h1234);     // duplicate load
        send_item(CMD_PROBE, 32'h1111_1111, 16'h10);      // miss
        send_item(CMD_PROBE, 32'hA5A5_5A5A, 16'hFFFF);    // completes
        send_item(CMD_PROBE, 32'hA5A5_5A5A, 16'hFFFF);    // after completion
        wait_drained();
        write_reg(REG_TERM_COUNT, 13'd0);                  // acts as one
        write_reg(REG_MAX_FOUND, 13'd2);
        send_item(CMD_QUERY, 32'd0, 16'd0);
        repeat (4) send_item(CMD_LOAD, $urandom, 16'($urandom)); // last two flagged
        send_item(CMD_PROBE, 32'h5, 16'h5);
        wait_drained();
        write_reg(REG_MAX_FOUND, 13'd0);
        send_item(CMD_LOAD, 32'h77, 16'h77);
        wait_drained();
        write_reg(REG_TERM_COUNT, 13'd31);                 // acts as sixteen
        write_reg(REG_MAX_FOUND, 13'd8191);
        send_item(CMD_QUERY, 32'd0, 16'd0);
        send_item(CMD_LOAD, 32'h42, 16'hFFFF);
        repeat (20) send_item(CMD_PROBE, 32'h42, 16'hFFFF, 0); // sum saturates
        wait_drained();
    endtask

    // fill the table past its size, with a long receiver hold-off
    task automatic test_table_full();
        write_reg(REG_TERM_COUNT, 13'd2);
        write_reg(REG_MAX_FOUND, 13'd4096);
        send_item(CMD_QUERY, 32'd0, 16'd0);
        hold_cycles = 400;
        for (int i = 0; i < ENTRIES + 3; i++) send_item(CMD_LOAD, 32'h100 + i, 16'(i), 0);
        for (int i = 0; i < 6; i++) send_item(CMD_PROBE, 32'h100 + i * 40, 16'(i), 0);
        wait_drained();
    endtask

    // random query sequences over several settings
    task automatic test_random(int n);
        logic [31:0] pg;
        int unsigned r;
        random_stall = 1;
        for (int k = 0; k < n; k++) begin
            if (k % 80 == 0) begin
                wait_drained();
                case ((k / 80) % 4)
                    0: write_reg(REG_TERM_COUNT, 13'd1);
                    1: write_reg(REG_TERM_COUNT, 13'd3);
                    2: write_reg(REG_TERM_COUNT, 13'd16);
                    default: write_reg(REG_TERM_COUNT, 13'($urandom_range(2, 5)));
                endcase
                write_reg(REG_MAX_FOUND,
                          (k / 80) % 3 == 0 ? 13'd4 : 13'($urandom_range(1, 4096)));
                send_item(CMD_QUERY, $urandom, 16'($urandom));
                page_pool.delete();
            end
            r = $urandom_range(0, 99);
            if (k % 20 < 4) random_stall = 0;
            else random_stall = 1;
            if (r < 2) send_item(CMD_CHUNK, $urandom, 16'($urandom));
            else if (r < 35 || page_pool.size() == 0)
                send_item(CMD_LOAD, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 63),
                          16'($urandom));
            else begin
                pg = (r < 92) ? page_pool[$urandom_range(0, page_pool.size() - 1)] : $urandom;
                send_item(CMD_PROBE, pg, 16'($urandom));
            end
        end
        wait_drained();
        random_stall = 0;
    endtask

    initial begin
        mismatch_count = 0;
        result_count = 0;
        hit_count = 0;
        item_count = 0;
        hold_cycles = 0;
        random_stall = 0;
        terms_reg = 1;
        max_found_reg = 16;
        tbl_fill = 0;
        found_total = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = CMD_QUERY;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_TERM_COUNT;
        i_cfg_data = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_table_full();
        test_random(400);

        $display("%0d items sent, %0d results checked, %0d emitted pages",
                 item_count, result_count, hit_count);
        $display("covered all commands, table overflow, found list limit, saturation");
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
